// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic       scrolled;
  } out_item_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

endpackage

// ===== rtl/core/tcw_cell_ram.sv =====
module tcw_cell_ram #(
  parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  tcw_pkg::cell_t           wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output tcw_pkg::cell_t           rdata
);

  tcw_pkg::cell_t mem [DEPTH];
  tcw_pkg::cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tcw_engine.sv =====
module tcw_engine #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::in_item_t   in_data,
  input  logic [7:0]          attr,
  output logic                res_valid,
  input  logic                res_ready,
  output tcw_pkg::out_item_t  res_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int NCOPY = (ROWS - 1) * COLS;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  tcw_pkg::out_item_t res_r, res_nxt;
  logic               rd_pend_r, rd_pend_nxt;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr, acc_addr;
  tcw_pkg::cell_t     wdata, rdata, blank;

  logic [RW-1:0]      in_row_c, step_row, acc_row;
  logic [CW-1:0]      in_col_c, step_col, acc_col;
  logic               last_row, last_col, is_nl, is_bs, ovf;

  tcw_cell_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign blank    = '{attr: attr, ch: tcw_pkg::CH_SPACE};
  assign last_row = (row_r == RW'(ROWS - 1));
  assign last_col = (col_r == CW'(COLS - 1));
  assign is_nl    = (in_data.char_code == tcw_pkg::CH_NEWLINE);
  assign is_bs    = (in_data.char_code == tcw_pkg::CH_BACKSPACE);

  always_comb begin
    in_row_c = (32'(in_data.row) >= ROWS) ? RW'(ROWS - 1) : RW'(in_data.row);
    in_col_c = (32'(in_data.col) >= COLS) ? CW'(COLS - 1) : CW'(in_data.col);
  end

  // cursor step for write char; row stays put on overflow (scroll follows)
  always_comb begin
    step_row = row_r;
    step_col = col_r;
    ovf      = 1'b0;
    if (is_nl) begin
      step_col = '0;
      if (last_row) begin
        ovf = 1'b1;
      end else begin
        step_row = row_r + RW'(1);
      end
    end else if (is_bs) begin
      if (col_r != '0) begin
        step_col = col_r - CW'(1);
      end else if (row_r != '0) begin
        step_row = row_r - RW'(1);
        step_col = CW'(COLS - 1);
      end
    end else if (last_col) begin
      step_col = '0;
      if (last_row) begin
        ovf = 1'b1;
      end else begin
        step_row = row_r + RW'(1);
      end
    end else begin
      step_col = col_r + CW'(1);
    end
  end

  always_comb begin
    if (in_data.op == tcw_pkg::OP_READ) begin
      acc_row = in_row_c;
      acc_col = in_col_c;
    end else if (is_bs) begin
      acc_row = step_row;
      acc_col = step_col;
    end else begin
      acc_row = row_r;
      acc_col = col_r;
    end
    acc_addr = AW'(32'(acc_row) * COLS + 32'(acc_col));
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    res_nxt     = res_r;
    rd_pend_nxt = rd_pend_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = acc_addr;
    raddr       = acc_addr;
    wdata       = blank;
    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        waddr = cnt_r[AW-1:0];
        wdata = '{attr: tcw_pkg::ATTR_RESET, ch: tcw_pkg::CH_SPACE};
        if (cnt_r == CNTW'(DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt     = '0;
          rd_pend_nxt = 1'b0;
          state_nxt   = S_RESP;
          res_nxt     = '0;
          unique case (in_data.op)
            tcw_pkg::OP_WRITE: begin
              row_nxt = step_row;
              col_nxt = step_col;
              we      = !is_nl;
              wdata   = is_bs ? blank
                              : tcw_pkg::cell_t'{attr: attr, ch: in_data.char_code};
              if (ovf) begin
                res_nxt.scrolled = 1'b1;
                state_nxt        = S_SCROLL;
              end
            end
            tcw_pkg::OP_SET: begin
              row_nxt = in_row_c;
              col_nxt = in_col_c;
            end
            tcw_pkg::OP_READ: begin
              re          = 1'b1;
              rd_pend_nxt = 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
          res_nxt.cursor_row = 5'(row_nxt);
          res_nxt.cursor_col = 7'(col_nxt);
        end
      end
      S_SCROLL: begin
        // read runs one cell ahead of the write, one row apart
        re    = (32'(cnt_r) < NCOPY);
        raddr = AW'(32'(cnt_r) + COLS);
        we    = (cnt_r != '0);
        waddr = AW'(32'(cnt_r) - 1);
        wdata = (32'(cnt_r) <= NCOPY) ? rdata : blank;
        if (cnt_r == CNTW'(DEPTH)) begin
          state_nxt = S_RESP;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r[AW-1:0];
        if (cnt_r == CNTW'(DEPTH - 1)) begin
          state_nxt = S_RESP;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      cnt_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res_data = res_r;
    if (rd_pend_r) begin
      res_data.read_char = rdata.ch;
      res_data.read_attr = rdata.attr;
    end
  end

endmodule

// ===== rtl/core/text_console_writer_core.sv =====
// Text console engine: a ROWS x COLS screen of character/attribute cells in one
// single-port-write, registered-read memory, plus a cursor. Write char, set
// cursor and read cell go from accept straight to the result state; a read's
// data is the registered memory read issued at accept. A write that runs past
// the last row scrolls through a memory copy sweep before its result; clear
// screen sweeps the memory. After reset the memory is blanked with attribute
// 15 in a sweep over all ROWS*COLS cells (2000 at 80x25), during which
// in_ready stays low; cfg writes are taken at any time. The memory port (one
// write, one read per cycle) sets the sweep lengths. A finished result waits
// in an output register, so the next item is accepted while it is still
// pending.
module text_console_writer_core #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0]         attr_r;
  logic               out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t out_data_r;
  logic               res_valid, res_ready;
  tcw_pkg::out_item_t res_data;

  tcw_engine #(.COLS(COLS), .ROWS(ROWS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .attr      (attr_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/tcw_checker.sv =====
module tcw_checker #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tcw_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while first in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.cursor_row) < ROWS) && (32'(out_data.cursor_col) < COLS))
    else $error("cursor off screen");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |->
      (out_data.cursor_row == 5'(ROWS - 1)) && (out_data.cursor_col == '0))
    else $error("scroll left cursor off last row start");

endmodule

bind text_console_writer_core tcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/console_checker.sv =====
module console_checker
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         mismatches,
  output int         pending
);

  localparam int COLS  = COLS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;

  cell_t      screen_copy [CELLS];
  int         cur_r;
  int         cur_c;
  logic [7:0] text_attr;
  out_item_t  cursor_view_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic cell_t blank_cell();
    cell_t b;
    b.attr = text_attr;
    b.ch   = CH_SPACE;
    return b;
  endfunction

  task automatic blank_screen();
    for (int i = 0; i < CELLS; i++) screen_copy[i] = blank_cell();
  endtask

  task automatic scroll_screen();
    for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_copy[i] = screen_copy[i + COLS];
    for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen_copy[i] = blank_cell();
  endtask

  task automatic console_step(input in_item_t it, output out_item_t res);
    int r;
    int c;
    res = '0;
    case (it.op)
      OP_WRITE: begin
        if (it.char_code == CH_NEWLINE) begin
          cur_r++;
          cur_c = 0;
        end else if (it.char_code == CH_BACKSPACE) begin
          if (cur_c > 0) begin
            cur_c--;
          end else if (cur_r > 0) begin
            cur_r--;
            cur_c = COLS - 1;
          end
          screen_copy[cur_r * COLS + cur_c] = blank_cell();
        end else begin
          screen_copy[cur_r * COLS + cur_c] = {text_attr, it.char_code};
          cur_c++;
          if (cur_c >= COLS) begin
            cur_c = 0;
            cur_r++;
          end
        end
        if (cur_r >= ROWS) begin
          scroll_screen();
          cur_r = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      OP_SET: begin
        cur_r = (it.row >= ROWS) ? ROWS - 1 : int'(it.row);
        cur_c = (it.col >= COLS) ? COLS - 1 : int'(it.col);
      end
      OP_READ: begin
        r = (it.row >= ROWS) ? ROWS - 1 : int'(it.row);
        c = (it.col >= COLS) ? COLS - 1 : int'(it.col);
        res.read_char = screen_copy[r * COLS + c].ch;
        res.read_attr = screen_copy[r * COLS + c].attr;
      end
      OP_CLEAR: begin
        blank_screen();
        cur_r = 0;
        cur_c = 0;
      end
    endcase
    res.cursor_row = cur_r[4:0];
    res.cursor_col = cur_c[6:0];
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t res;
    if (!rst_n) begin
      text_attr = ATTR_RESET;
      blank_screen();
      cur_r = 0;
      cur_c = 0;
      cursor_view_q.delete();
    end else begin
      if (cfg_we) text_attr = cfg_wdata;
      if (out_valid && out_ready) begin
        if (cursor_view_q.size() == 0) begin
          note_mismatch("result item with nothing pending");
        end else begin
          want = cursor_view_q.pop_front();
          check_field("cursor_row", 8'(out_data.cursor_row), 8'(want.cursor_row));
          check_field("cursor_col", 8'(out_data.cursor_col), 8'(want.cursor_col));
          check_field("read_char", out_data.read_char, want.read_char);
          check_field("read_attr", out_data.read_attr, want.read_attr);
          check_field("scrolled", 8'(out_data.scrolled), 8'(want.scrolled));
        end
      end
      if (in_valid && in_ready) begin
        console_step(in_data, res);
        cursor_view_q.push_back(res);
      end
    end
    pending <= cursor_view_q.size();
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import tcw_pkg::*;

  localparam int SWEEP       = COLS_DEF * ROWS_DEF;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 144;
  localparam int CYCLE_LIMIT = 1300 * (SWEEP + 3 + 2 * 18) * 4 + SWEEP;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_data;
  int         mismatches;
  int         pending;
  int         cycles    = 0;
  bit         steady    = 1'b0;
  int         gap_odds  = 4;

  text_console_writer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  console_checker mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // result side back-pressure
  initial begin
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!steady && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  function automatic in_item_t console_op(logic [1:0] op, logic [7:0] ch,
                                          logic [4:0] row, logic [6:0] col);
    in_item_t it;
    it.op        = op;
    it.char_code = ch;
    it.row       = row;
    it.col       = col;
    return it;
  endfunction

  function automatic in_item_t random_console_op();
    in_item_t it;
    int pick;
    it = in_item_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.op = OP_WRITE;
      while (it.char_code == CH_NEWLINE || it.char_code == CH_BACKSPACE)
        it.char_code = 8'($urandom_range(0, 255));
    end else if (pick < 62) begin
      it.op        = OP_WRITE;
      it.char_code = CH_NEWLINE;
    end else if (pick < 68) begin
      it.op        = OP_WRITE;
      it.char_code = CH_BACKSPACE;
    end else if (pick < 80) begin
      it.op = OP_SET;
      // lean toward the bottom and right edges so wraps and scrolls happen
      if ($urandom_range(0, 2) == 0) it.row = 5'($urandom_range(24, 31));
      if ($urandom_range(0, 3) == 0) it.col = 7'($urandom_range(72, 127));
    end else if (pick < 98) begin
      it.op = OP_READ;
    end else begin
      it.op = OP_CLEAR;
    end
    return it;
  endfunction

  task automatic send_op(in_item_t it);
    if (!steady && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_attr(logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset attribute, edges, clamping, wrap, scroll, erase, clear
    send_op(console_op(OP_READ, 8'd0, 5'd0, 7'd0));
    send_op(console_op(OP_WRITE, 8'd65, 5'd0, 7'd0));
    send_op(console_op(OP_WRITE, 8'd0, 5'd31, 7'd127));
    send_op(console_op(OP_WRITE, 8'd255, 5'd0, 7'd0));
    send_op(console_op(OP_WRITE, CH_BACKSPACE, 5'd0, 7'd0));
    send_op(console_op(OP_WRITE, CH_NEWLINE, 5'd0, 7'd0));
    send_op(console_op(OP_SET, 8'd0, 5'd0, 7'd0));
    send_op(console_op(OP_WRITE, CH_BACKSPACE, 5'd0, 7'd0));
    send_op(console_op(OP_READ, 8'd0, 5'd0, 7'd0));
    send_op(console_op(OP_SET, 8'd0, 5'd31, 7'd127));
    send_op(console_op(OP_WRITE, 8'd90, 5'd0, 7'd0));
    send_op(console_op(OP_READ, 8'd0, 5'd23, 7'd79));
    send_op(console_op(OP_READ, 8'd0, 5'd31, 7'd127));
    send_op(console_op(OP_SET, 8'd0, 5'd5, 7'd0));
    send_op(console_op(OP_WRITE, CH_BACKSPACE, 5'd0, 7'd0));
    send_op(console_op(OP_SET, 8'd0, 5'd24, 7'd3));
    send_op(console_op(OP_WRITE, CH_NEWLINE, 5'd0, 7'd0));
    send_op(console_op(OP_CLEAR, 8'd0, 5'd0, 7'd0));
    send_op(console_op(OP_READ, 8'd0, 5'd12, 7'd40));
    settle();
    write_attr(8'h00);
    send_op(console_op(OP_WRITE, 8'd113, 5'd0, 7'd0));
    send_op(console_op(OP_READ, 8'd0, 5'd0, 7'd0));
    settle();
    write_attr(8'hFF);
    send_op(console_op(OP_WRITE, CH_BACKSPACE, 5'd0, 7'd0));
    send_op(console_op(OP_READ, 8'd0, 5'd0, 7'd0));
    send_op(console_op(OP_SET, 8'd0, 5'd24, 7'd79));
    send_op(console_op(OP_WRITE, 8'd120, 5'd0, 7'd0));

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_attr((p == 3) ? 8'h00 : (p == 6) ? 8'hFF : 8'($urandom_range(0, 255)));
      gap_odds = (p % 3 == 1) ? 0 : (p % 3 == 0) ? 3 : 8;
      steady   = (p == N_PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_op(random_console_op());
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
